>>> src/keop_pkg.sv
package keop_pkg;

   localparam int INDEX_BITS  = 16;
   localparam int ELEM_BITS   = 16;
   localparam int KEY_SHIFT_A = 11;
   localparam int KEY_SHIFT_B = 29;
   localparam int X1_BITS     = KEY_SHIFT_B + ELEM_BITS;

   localparam int CSR_ADDR_BITS = 6;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [2:0] REG_OPERATION     = 3'd0;
   localparam logic [2:0] REG_OPERAND_WIDTH = 3'd1;
   localparam logic [2:0] REG_INDEX_MODE    = 3'd2;
   localparam logic [2:0] REG_FIXED_OPERAND = 3'd3;
   localparam logic [2:0] REG_KEY_SEED      = 3'd4;
   localparam logic [2:0] REG_KEY_ADD       = 3'd5;
   localparam logic [2:0] REG_KEY_MUL       = 3'd6;
   localparam logic [2:0] REG_KEY_XOR       = 3'd7;

   localparam logic [4:0] OP_ADD  = 5'd0;
   localparam logic [4:0] OP_SUB  = 5'd1;
   localparam logic [4:0] OP_MUL  = 5'd2;
   localparam logic [4:0] OP_AND  = 5'd3;
   localparam logic [4:0] OP_OR   = 5'd4;
   localparam logic [4:0] OP_XOR  = 5'd5;
   localparam logic [4:0] OP_SHL  = 5'd6;
   localparam logic [4:0] OP_LSHR = 5'd7;
   localparam logic [4:0] OP_ASHR = 5'd8;
   localparam logic [4:0] OP_EQ   = 5'd9;
   localparam logic [4:0] OP_NE   = 5'd10;
   localparam logic [4:0] OP_UGT  = 5'd11;
   localparam logic [4:0] OP_UGE  = 5'd12;
   localparam logic [4:0] OP_ULT  = 5'd13;
   localparam logic [4:0] OP_ULE  = 5'd14;
   localparam logic [4:0] OP_SGT  = 5'd15;
   localparam logic [4:0] OP_SGE  = 5'd16;
   localparam logic [4:0] OP_SLT  = 5'd17;
   localparam logic [4:0] OP_SLE  = 5'd18;

   localparam logic [1:0] MODE_BYTES       = 2'd0;
   localparam logic [1:0] MODE_FIXED_LEFT  = 2'd1;
   localparam logic [1:0] MODE_FIXED_RIGHT = 2'd2;

   localparam logic [4:0] WIDTH_MIN = 5'd1;
   localparam logic [4:0] WIDTH_MAX = 5'd16;
   localparam logic [4:0] WIDTH_RESET = 5'd8;

endpackage

>>> src/keyed_op_table_encoder_core.sv
// Channel   Direction  Word                      Handshake
// req       in         tdata[15:0] table_index   req_tvalid / req_tready
// rsp       out        tdata[47:0] plain_value,  rsp_tvalid / rsp_tready
//                      key_value, encoded_cell
// csr       in         APB-style, 64-bit data    psel / penable / pwrite / pready
//
// One word per cycle sustained while rsp is ready, through a four-stage pipeline
// (operand select, ALU and key multiply, key add and first xor-shift, output).
// Synchronous active-high reset empties the pipeline and restores register defaults.
// Each stage advances when it is empty or the stage after it advances; a stall
// on rsp holds every word in place.
module keyed_op_table_encoder_core
   import keop_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [15:0]              req_tdata,   // [15:0] table_index
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [47:0]              rsp_tdata,   // [15:0] plain_value, [31:16] key_value,
                                                 // [47:32] encoded_cell
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   logic [4:0]  operation_ff;
   logic [4:0]  operand_width_ff;
   logic [1:0]  index_mode_ff;
   logic [15:0] fixed_operand_ff;
   logic [63:0] key_seed_ff;
   logic [31:0] key_add_ff;
   logic [31:0] key_mul_ff;
   logic [15:0] key_xor_ff;

   logic [2:0]  csr_index;
   logic        csr_write;

   assign pready    = 1'b1;
   assign csr_index = paddr[CSR_ADDR_BITS-1:3];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         operation_ff     <= OP_ADD;
         operand_width_ff <= WIDTH_RESET;
         index_mode_ff    <= MODE_BYTES;
         fixed_operand_ff <= '0;
         key_seed_ff      <= '0;
         key_add_ff       <= '0;
         key_mul_ff       <= 32'd1;
         key_xor_ff       <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_OPERATION:     operation_ff     <= pwdata[4:0];
            REG_OPERAND_WIDTH: operand_width_ff <= pwdata[4:0];
            REG_INDEX_MODE:    index_mode_ff    <= pwdata[1:0];
            REG_FIXED_OPERAND: fixed_operand_ff <= pwdata[15:0];
            REG_KEY_SEED:      key_seed_ff      <= pwdata;
            REG_KEY_ADD:       key_add_ff       <= pwdata[31:0];
            REG_KEY_MUL:       key_mul_ff       <= pwdata[31:0];
            REG_KEY_XOR:       key_xor_ff       <= pwdata[15:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_OPERATION:     prdata = 64'(operation_ff);
         REG_OPERAND_WIDTH: prdata = 64'(operand_width_ff);
         REG_INDEX_MODE:    prdata = 64'(index_mode_ff);
         REG_FIXED_OPERAND: prdata = 64'(fixed_operand_ff);
         REG_KEY_SEED:      prdata = key_seed_ff;
         REG_KEY_ADD:       prdata = 64'(key_add_ff);
         REG_KEY_MUL:       prdata = 64'(key_mul_ff);
         REG_KEY_XOR:       prdata = 64'(key_xor_ff);
      endcase
   end

   // effective width, operand mask and element mask
   logic [4:0]  width;
   logic [3:0]  width_m1;
   logic [15:0] op_mask;
   logic [15:0] sign_bit;
   logic        is_cmp;
   logic [15:0] elem_mask;

   always_comb begin
      priority if (operand_width_ff < WIDTH_MIN) begin
         width = WIDTH_MIN;
      end else if (operand_width_ff > WIDTH_MAX) begin
         width = WIDTH_MAX;
      end else begin
         width = operand_width_ff;
      end
      width_m1  = 4'(width - 5'd1);
      op_mask   = 16'((17'd1 << width) - 17'd1);
      sign_bit  = 16'd1 << width_m1;
      is_cmp    = (operation_ff >= OP_EQ) && (operation_ff <= OP_SLE);
      elem_mask = (is_cmp || width <= 5'd8) ? 16'h00FF : 16'hFFFF;
   end

   // stage handshake
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4       = !v4_ff || rsp_tready;
   assign rdy3       = !v3_ff || rdy4;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign rsp_tvalid = v4_ff;

   assign v1_in = rdy1 ? req_tvalid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;
   assign v4_in = rdy4 ? v3_ff : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // stage 1: index and operand select
   logic [15:0] idx1_ff, a1_ff, b1_ff;
   logic [15:0] idx1_in, a1_in, b1_in;

   always_comb begin
      idx1_in = 16'(req_tdata[INDEX_BITS-1:0]);
      unique case (index_mode_ff)
         MODE_FIXED_LEFT: begin
            a1_in = fixed_operand_ff;
            b1_in = idx1_in;
         end
         MODE_FIXED_RIGHT: begin
            a1_in = idx1_in;
            b1_in = fixed_operand_ff;
         end
         default: begin
            a1_in = {8'd0, idx1_in[15:8]};
            b1_in = {8'd0, idx1_in[7:0]};
         end
      endcase
      a1_in = a1_in & op_mask;
      b1_in = b1_in & op_mask;
   end

   always_ff @(posedge clock) begin
      if (rdy1) begin
         idx1_ff <= idx1_in;
         a1_ff   <= a1_in;
         b1_ff   <= b1_in;
      end
   end

   // stage 2: ALU and key multiply
   logic [15:0] val2_ff, val2_in;
   logic [47:0] prod2_ff, prod2_in;
   logic [63:0] base_ff, base_in;
   logic [31:0] mul_full;
   logic [15:0] sext, ashr_res, sa, sb;
   logic        shift_big;

   assign base_in  = key_seed_ff + 64'(key_add_ff);
   assign prod2_in = 48'(idx1_ff) * 48'(key_mul_ff);

   always_comb begin
      mul_full  = 32'(a1_ff) * 32'(b1_ff);
      shift_big = b1_ff >= 16'(width);
      sext      = a1_ff | (((a1_ff & sign_bit) != 16'd0) ? ~op_mask : 16'd0);
      ashr_res  = 16'($signed(sext) >>> b1_ff[3:0]);
      sa        = a1_ff ^ sign_bit;
      sb        = b1_ff ^ sign_bit;
      unique case (operation_ff)
         OP_ADD:  val2_in = (a1_ff + b1_ff) & op_mask;
         OP_SUB:  val2_in = (a1_ff - b1_ff) & op_mask;
         OP_MUL:  val2_in = mul_full[15:0] & op_mask;
         OP_AND:  val2_in = a1_ff & b1_ff;
         OP_OR:   val2_in = a1_ff | b1_ff;
         OP_XOR:  val2_in = a1_ff ^ b1_ff;
         OP_SHL:  val2_in = shift_big ? 16'd0 : (a1_ff << b1_ff[3:0]) & op_mask;
         OP_LSHR: val2_in = shift_big ? 16'd0 : a1_ff >> b1_ff[3:0];
         OP_ASHR: val2_in = shift_big ? 16'd0 : ashr_res & op_mask;
         OP_EQ:   val2_in = 16'(a1_ff == b1_ff);
         OP_NE:   val2_in = 16'(a1_ff != b1_ff);
         OP_UGT:  val2_in = 16'(a1_ff > b1_ff);
         OP_UGE:  val2_in = 16'(a1_ff >= b1_ff);
         OP_ULT:  val2_in = 16'(a1_ff < b1_ff);
         OP_ULE:  val2_in = 16'(a1_ff <= b1_ff);
         OP_SGT:  val2_in = 16'(sa > sb);
         OP_SGE:  val2_in = 16'(sa >= sb);
         OP_SLT:  val2_in = 16'(sa < sb);
         OP_SLE:  val2_in = 16'(sa <= sb);
         default: val2_in = 16'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      if (rdy2) begin
         val2_ff  <= val2_in;
         prod2_ff <= prod2_in;
      end
   end

   // stage 3: key sum and first xor-shift
   logic [15:0]        val3_ff;
   logic [X1_BITS-1:0] x1_ff, x1_in;
   logic [63:0]        key_sum, key_x1;

   always_comb begin
      key_sum = base_ff + 64'(prod2_ff);
      key_x1  = key_sum ^ (key_sum >> KEY_SHIFT_A);
      x1_in   = key_x1[X1_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         val3_ff <= val2_ff;
         x1_ff   <= x1_in;
      end
   end

   // stage 4: second xor-shift, mask and output
   logic [15:0] plain_ff, key_ff, enc_ff;
   logic [15:0] key_in, enc_in;

   always_comb begin
      key_in = (x1_ff[ELEM_BITS-1:0] ^ x1_ff[KEY_SHIFT_B +: ELEM_BITS] ^ key_xor_ff)
               & elem_mask;
      enc_in = (val3_ff ^ key_in) & elem_mask;
   end

   always_ff @(posedge clock) begin
      if (rdy4) begin
         plain_ff <= val3_ff;
         key_ff   <= key_in;
         enc_ff   <= enc_in;
      end
   end

   assign rsp_tdata = {enc_ff, key_ff, plain_ff};

endmodule

>>> src/keop_checker.sv
module keop_checker
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp word valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled rsp word changed or dropped");

   a_cell_xor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47:32] == (rsp_tdata[15:0] ^ rsp_tdata[31:16]))
      else $error("encoded cell differs from plain xor key");

   a_key_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[31:24] == 8'd0 && rsp_tdata[15:8] == 8'd0
      |-> rsp_tdata[47:40] == 8'd0)
      else $error("encoded cell high byte set with byte-wide plain and key");

endmodule

bind keyed_op_table_encoder_core keop_checker u_keop_checker (.*);

>>> verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import keop_pkg::*;

   localparam logic [4:0] OP_UNUSED_LOW = 5'd19;
   localparam logic [4:0] OP_UNUSED_TOP = 5'd31;
   localparam logic [1:0] MODE_UNUSED   = 2'd3;
   localparam logic [4:0] WIDTH_ZERO    = 5'd0;
   localparam logic [4:0] WIDTH_OVER    = 5'd31;
   localparam int         HOLD_CYCLES   = 300;

   typedef struct packed {
      logic [15:0] encoded_cell;
      logic [15:0] key_value;
      logic [15:0] plain_value;
   } cell_word_type;

   class encoder_scoreboard_type;
      logic [4:0]    op_code;
      logic [4:0]    width_reg;
      logic [1:0]    mode_reg;
      logic [15:0]   fixed_reg;
      logic [63:0]   seed_reg;
      logic [31:0]   add_reg;
      logic [31:0]   mul_reg;
      logic [15:0]   xor_reg;
      cell_word_type cells_due[$];
      int            errors;
      int            noted;
      int            checked;

      function new();
         op_code   = OP_ADD;
         width_reg = WIDTH_RESET;
         mode_reg  = MODE_BYTES;
         fixed_reg = '0;
         seed_reg  = '0;
         add_reg   = '0;
         mul_reg   = 32'd1;
         xor_reg   = '0;
         errors    = 0;
         noted     = 0;
         checked   = 0;
      endfunction

      function void write_reg(logic [2:0] reg_idx, logic [63:0] value);
         case (reg_idx)
            REG_OPERATION:     op_code   = value[4:0];
            REG_OPERAND_WIDTH: width_reg = value[4:0];
            REG_INDEX_MODE:    mode_reg  = value[1:0];
            REG_FIXED_OPERAND: fixed_reg = value[15:0];
            REG_KEY_SEED:      seed_reg  = value;
            REG_KEY_ADD:       add_reg   = value[31:0];
            REG_KEY_MUL:       mul_reg   = value[31:0];
            REG_KEY_XOR:       xor_reg   = value[15:0];
            default: ;
         endcase
      endfunction

      function cell_word_type compute_cell(logic [15:0] table_index);
         int unsigned   w;
         logic [63:0]   m, sgn, a, b, r, sa, sb, x, emask, key;
         logic          is_cmp;
         cell_word_type out_word;
         w = (width_reg == 0) ? 1 : ((width_reg > 16) ? 16 : width_reg);
         m = (64'd1 << w) - 64'd1;
         sgn = 64'd1 << (w - 1);
         case (mode_reg)
            MODE_FIXED_LEFT: begin
               a = {48'd0, fixed_reg};
               b = {48'd0, table_index};
            end
            MODE_FIXED_RIGHT: begin
               a = {48'd0, table_index};
               b = {48'd0, fixed_reg};
            end
            default: begin
               a = {56'd0, table_index[15:8]};
               b = {56'd0, table_index[7:0]};
            end
         endcase
         a = a & m;
         b = b & m;
         sa = a ^ sgn;
         sb = b ^ sgn;
         is_cmp = (op_code >= OP_EQ) && (op_code <= OP_SLE);
         case (op_code)
            OP_ADD:  r = a + b;
            OP_SUB:  r = a - b;
            OP_MUL:  r = a * b;
            OP_AND:  r = a & b;
            OP_OR:   r = a | b;
            OP_XOR:  r = a ^ b;
            OP_SHL:  r = (b >= w) ? 64'd0 : (a << b);
            OP_LSHR: r = (b >= w) ? 64'd0 : (a >> b);
            OP_ASHR: begin
               if (b >= w) begin
                  r = 64'd0;
               end else begin
                  r = a >> b;
                  if ((a & sgn) != 0) r = r | (m & ~(m >> b));
               end
            end
            OP_EQ:   r = (a == b);
            OP_NE:   r = (a != b);
            OP_UGT:  r = (a > b);
            OP_UGE:  r = (a >= b);
            OP_ULT:  r = (a < b);
            OP_ULE:  r = (a <= b);
            OP_SGT:  r = (sa > sb);
            OP_SGE:  r = (sa >= sb);
            OP_SLT:  r = (sa < sb);
            OP_SLE:  r = (sa <= sb);
            default: r = 64'd0;
         endcase
         r = r & m;
         emask = (is_cmp || w <= 8) ? 64'hFF : 64'hFFFF;
         x = seed_reg + {32'd0, add_reg};
         x = x + {48'd0, table_index} * {32'd0, mul_reg};
         x = x ^ (x >> KEY_SHIFT_A);
         x = x ^ (x >> KEY_SHIFT_B);
         key = (x ^ {48'd0, xor_reg}) & emask;
         out_word.plain_value  = r[15:0];
         out_word.key_value    = key[15:0];
         out_word.encoded_cell = 16'((r ^ key) & emask);
         return out_word;
      endfunction

      function void note_index(logic [15:0] table_index);
         cells_due = {cells_due, compute_cell(table_index)};
         noted++;
      endfunction

      function void check_word(logic [47:0] word);
         cell_word_type got, want;
         got = word;
         if (cells_due.size() == 0) begin
            $error("unexpected response word %h", word);
            errors++;
            return;
         end
         want = cells_due.pop_front();
         checked++;
         if (got.plain_value !== want.plain_value) begin
            $error("plain_value mismatch: expected %h, got %h",
                   want.plain_value, got.plain_value);
            errors++;
         end
         if (got.key_value !== want.key_value) begin
            $error("key_value mismatch: expected %h, got %h",
                   want.key_value, got.key_value);
            errors++;
         end
         if (got.encoded_cell !== want.encoded_cell) begin
            $error("encoded_cell mismatch: expected %h, got %h",
                   want.encoded_cell, got.encoded_cell);
            errors++;
         end
      endfunction

      function int pending();
         return cells_due.size();
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [15:0]              req_tdata = '0;    // [15:0] table_index
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [47:0]              rsp_tdata;         // [15:0] plain_value, [31:16] key_value,
                                                // [47:32] encoded_cell
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   encoder_scoreboard_type sb = new();

   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          hold_req = 1'b0;
   int          hold_left = 0;
   int          settings_done = 0;
   logic [63:0] key_seed_v = '0;
   logic [31:0] key_add_v = '0;
   logic [31:0] key_mul_v = 32'd1;
   logic [15:0] key_xor_v = '0;

   keyed_op_table_encoder_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   always #2 clock = ~clock;

   initial begin
      #2ms;
      $display("Some tests failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_index(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) sb.check_word(rsp_tdata);
   end

   always @(posedge clock) begin
      if (hold_req) begin
         hold_left = HOLD_CYCLES;
         hold_req = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   task automatic send_index(input logic [15:0] table_index);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= table_index;
      do @(posedge clock); while (!req_tready);
   endtask

   // hold off new words until every cell is back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] reg_idx, input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.write_reg(reg_idx, value);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [4:0] op, input logic [4:0] width,
                                input logic [1:0] mode, input logic [15:0] fixed,
                                input logic [63:0] junk);
      drain();
      csr_write(REG_OPERATION,     {junk[63:5], op});
      csr_write(REG_OPERAND_WIDTH, {junk[63:5], width});
      csr_write(REG_INDEX_MODE,    {junk[63:2], mode});
      csr_write(REG_FIXED_OPERAND, {junk[63:16], fixed});
      csr_write(REG_KEY_SEED,      key_seed_v);
      csr_write(REG_KEY_ADD,       {junk[63:32], key_add_v});
      csr_write(REG_KEY_MUL,       {junk[63:32], key_mul_v});
      csr_write(REG_KEY_XOR,       {junk[63:16], key_xor_v});
      settings_done++;
   endtask

   task automatic directed_cell(input logic [4:0] op, input logic [4:0] width,
                                input logic [1:0] mode, input logic [15:0] fixed,
                                input logic [15:0] table_index);
      apply_setting(op, width, mode, fixed, 64'd0);
      send_index(table_index);
   endtask

   task automatic random_setting();
      logic [4:0]  op, width;
      logic [15:0] fixed;
      op = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(19, 31))
                                       : 5'($urandom_range(0, 18));
      case ($urandom_range(0, 9))
         0:       width = 5'($urandom_range(17, 31));
         1:       width = WIDTH_ZERO;
         2:       width = WIDTH_MAX;
         3:       width = WIDTH_MIN;
         default: width = 5'($urandom_range(1, 16));
      endcase
      fixed = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 17));
      key_seed_v = {$urandom, $urandom};
      key_add_v  = $urandom;
      key_mul_v  = $urandom_range(0, 3) == 0 ? $urandom : ($urandom | 32'd1);
      key_xor_v  = 16'($urandom);
      apply_setting(op, width, 2'($urandom_range(0, 3)), fixed, {$urandom, $urandom});
   endtask

   function automatic logic [15:0] random_index();
      logic [31:0] r;
      r = $urandom;
      case (r[31:30])
         2'd0:    return {r[15:8], 3'b000, r[4:0]};
         2'd1:    return {r[16] ? 8'hFF : 8'h00, r[17] ? 8'h80 : 8'h7F};
         default: return r[15:0];
      endcase
   endfunction

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_index(16'h0000);
      send_index(16'hFFFF);
      directed_cell(OP_ADD,  WIDTH_MAX,  MODE_BYTES,       16'h0000, 16'hFFFF);
      directed_cell(OP_SUB,  WIDTH_MAX,  MODE_FIXED_LEFT,  16'h0000, 16'hFFFF);
      key_seed_v = '1;
      key_add_v  = '1;
      key_mul_v  = '1;
      key_xor_v  = '1;
      directed_cell(OP_MUL,  WIDTH_MAX,  MODE_FIXED_RIGHT, 16'hFFFF, 16'hFFFF);
      directed_cell(OP_AND,  WIDTH_ZERO, MODE_BYTES,       16'h0000, 16'hFFFF);
      directed_cell(OP_OR,   WIDTH_OVER, MODE_UNUSED,      16'h0000, 16'h1234);
      directed_cell(OP_XOR,  5'd17,      MODE_BYTES,       16'h0000, 16'hA55A);
      directed_cell(OP_SHL,  WIDTH_RESET, MODE_BYTES,      16'h0000, 16'h0109);
      directed_cell(OP_SHL,  WIDTH_MAX,  MODE_FIXED_RIGHT, 16'h000F, 16'h0001);
      directed_cell(OP_LSHR, WIDTH_RESET, MODE_BYTES,      16'h0000, 16'hF007);
      key_seed_v = {$urandom, $urandom};
      key_add_v  = '0;
      key_mul_v  = 32'h0000_0002;
      key_xor_v  = '0;
      directed_cell(OP_ASHR, WIDTH_RESET, MODE_BYTES,      16'h0000, 16'h8003);
      directed_cell(OP_ASHR, WIDTH_RESET, MODE_BYTES,      16'h0000, 16'h8008);
      directed_cell(OP_EQ,   WIDTH_MAX,  MODE_FIXED_LEFT,  16'h1234, 16'h1234);
      directed_cell(OP_NE,   5'd4,       MODE_BYTES,       16'h0000, 16'h0F0F);
      directed_cell(OP_UGT,  WIDTH_MIN,  MODE_BYTES,       16'h0000, 16'h0100);
      directed_cell(OP_UGE,  WIDTH_MAX,  MODE_FIXED_RIGHT, 16'h0000, 16'h0000);
      directed_cell(OP_ULT,  5'd12,      MODE_FIXED_LEFT,  16'h0FFF, 16'h0FFE);
      directed_cell(OP_ULE,  WIDTH_RESET, MODE_BYTES,      16'h0000, 16'h7F80);
      directed_cell(OP_SGT,  WIDTH_RESET, MODE_BYTES,      16'h0000, 16'h7F80);
      directed_cell(OP_SGE,  WIDTH_MAX,  MODE_FIXED_LEFT,  16'hFFFF, 16'h0000);
      directed_cell(OP_SLT,  5'd9,       MODE_FIXED_RIGHT, 16'h0100, 16'h00FF);
      directed_cell(OP_SLE,  WIDTH_MAX,  MODE_FIXED_LEFT,  16'h8000, 16'h7FFF);
      directed_cell(OP_UNUSED_LOW, 5'd12, MODE_BYTES,      16'h0000, 16'hFFFF);
      directed_cell(OP_UNUSED_TOP, 5'd4,  MODE_BYTES,      16'h0000, 16'h8181);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 72 : 0;
         recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 14 : 0;
         for (int s = 0; s < 6; s++) begin
            random_setting();
            for (int i = 0; i < 50; i++) begin
               if (phase == 2 && s == 2 && i == 0) hold_req = 1'b1;
               if (phase == 2 && s == 4 && i == 25) drain();
               send_index(random_index());
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      $display("Sent %0d table indexes and checked %0d cells over %0d register settings,",
               sb.noted, sb.checked, settings_done);
      $display("covering every operation, unused codes, all index modes and widths 0..31.");
      if (sb.errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> keyed_op_table_encoder_core.f
src/keop_pkg.sv
src/keyed_op_table_encoder_core.sv
src/keop_checker.sv
verif/tb.sv
